@@ rtl/core/line_position_pid_steering_macros.svh @@
// ----------------------------------------------------------------------------
// Line position PID steering - assertion macros
// Shared concurrent assertion forms for the steering checker.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_PID_STEERING_MACROS_SVH
`define LINE_POSITION_PID_STEERING_MACROS_SVH

// Check a condition whenever the trigger holds, same cycle.
`define LPPS_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check a condition in the cycle after the trigger.
`define LPPS_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ rtl/core/lpps_pkg.sv @@
// ----------------------------------------------------------------------------
// Line position PID steering - package
// Widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lpps_pkg;

    localparam int SENSOR_W   = 10;
    localparam int SUM_W      = 13;
    localparam int MAG_W      = 12;
    localparam int NUM_W      = 25;
    localparam int DEN_W      = 14;
    localparam int QUO_W      = 13;
    localparam int CNT_W      = 4;
    localparam int GAIN_W     = 24;
    localparam int DUTY_CFG_W = 7;
    localparam int LIMIT_W    = 16;
    localparam int DUTY_W     = 15;
    localparam int ERR_W      = 14;
    localparam int INTEG_W    = 17;
    localparam int DIFF_W     = 15;
    localparam int PROD_W     = 42;
    localparam int CORR_W     = 44;
    localparam int DUTY_Q_W   = 45;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CNT_W-1:0]        DIV_STEPS = 4'd13;
    localparam logic signed [ERR_W-1:0] ERR_FULL  = 14'sd7680;
    localparam logic [DUTY_W-1:0]       DUTY_MAX  = 15'd32512;

    localparam logic [GAIN_W-1:0]     RST_GAIN_P    = 24'd2293760;
    localparam logic [GAIN_W-1:0]     RST_GAIN_I    = 24'd655;
    localparam logic [GAIN_W-1:0]     RST_GAIN_D    = 24'd3932160;
    localparam logic [SENSOR_W-1:0]   RST_THRESHOLD = 10'd500;
    localparam logic [DUTY_CFG_W-1:0] RST_BASE_DUTY = 7'd91;
    localparam logic [DUTY_CFG_W-1:0] RST_MIN_DUTY  = 7'd61;
    localparam logic [DUTY_CFG_W-1:0] RST_MAX_DUTY  = 7'd96;
    localparam logic [LIMIT_W-1:0]    RST_INT_LIMIT = 16'd7680;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_BLACK_THRESHOLD,
        CFG_BASE_DUTY,
        CFG_MIN_DUTY,
        CFG_MAX_DUTY,
        CFG_INTEGRAL_LIMIT
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain_p;
        logic [GAIN_W-1:0]     gain_i;
        logic [GAIN_W-1:0]     gain_d;
        logic [SENSOR_W-1:0]   black_threshold;
        logic [DUTY_CFG_W-1:0] base_duty;
        logic [DUTY_CFG_W-1:0] min_duty;
        logic [DUTY_CFG_W-1:0] max_duty;
        logic [LIMIT_W-1:0]    integral_limit;
    } cfg_t;

    typedef struct packed {
        logic             all_black;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } scan_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_DUTY,
        ST_SAT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/lpps_scan_if.sv @@
// ----------------------------------------------------------------------------
// Line position PID steering - scan channel
// Valid/ready channel carrying one scan of five line sensors.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpps_scan_if;
    logic                          valid;
    logic                          ready;
    logic [lpps_pkg::SENSOR_W-1:0] sensor_0;
    logic [lpps_pkg::SENSOR_W-1:0] sensor_1;
    logic [lpps_pkg::SENSOR_W-1:0] sensor_2;
    logic [lpps_pkg::SENSOR_W-1:0] sensor_3;
    logic [lpps_pkg::SENSOR_W-1:0] sensor_4;

    modport source (
        output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
        input  ready
    );

    modport sink (
        input  valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/lpps_steer_if.sv @@
// ----------------------------------------------------------------------------
// Line position PID steering - steering channel
// Valid/ready channel carrying motor duties and the line error.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpps_steer_if;
    logic                               valid;
    logic                               ready;
    logic [lpps_pkg::DUTY_W-1:0]        left_duty;
    logic [lpps_pkg::DUTY_W-1:0]        right_duty;
    logic signed [lpps_pkg::ERR_W-1:0]  line_error;

    modport source (
        output valid, left_duty, right_duty, line_error,
        input  ready
    );

    modport sink (
        input  valid, left_duty, right_duty, line_error,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/lpps_front.sv @@
// ----------------------------------------------------------------------------
// Line position PID steering - front end
// Accepts a scan, forms the rounded centroid dividend and divisor, flags
// an all-black scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_front (
    lpps_scan_if.sink                     scan,
    input  logic [lpps_pkg::SENSOR_W-1:0] black_threshold,
    output logic                          push_valid,
    input  logic                          push_ready,
    output lpps_pkg::scan_t               push_data
);

    logic [lpps_pkg::MAG_W-1:0] left_w;
    logic [lpps_pkg::MAG_W-1:0] right_w;
    logic [lpps_pkg::MAG_W-1:0] mag;
    logic [lpps_pkg::SUM_W-1:0] sum;
    logic                       neg;
    logic                       any_white;

    assign scan.ready = push_ready;
    assign push_valid = scan.valid;

    always_comb
    begin
        left_w  = {1'b0, scan.sensor_0, 1'b0} + {2'b0, scan.sensor_0}
                  + {2'b0, scan.sensor_1};
        right_w = {1'b0, scan.sensor_4, 1'b0} + {2'b0, scan.sensor_4}
                  + {2'b0, scan.sensor_3};
        neg     = right_w > left_w;
        mag     = neg ? (right_w - left_w) : (left_w - right_w);
        sum     = {3'b0, scan.sensor_0} + {3'b0, scan.sensor_1}
                  + {3'b0, scan.sensor_2} + {3'b0, scan.sensor_3}
                  + {3'b0, scan.sensor_4};
        any_white = (scan.sensor_0 > black_threshold)
                  || (scan.sensor_1 > black_threshold)
                  || (scan.sensor_2 > black_threshold)
                  || (scan.sensor_3 > black_threshold)
                  || (scan.sensor_4 > black_threshold);

        push_data.all_black = !any_white;
        push_data.neg       = neg;
        push_data.num       = {1'b0, mag, 12'b0} + {3'b0, mag, 10'b0} + {12'b0, sum};
        push_data.den       = {sum, 1'b0};
    end

endmodule

`default_nettype wire

@@ rtl/core/lpps_queue.sv @@
// ----------------------------------------------------------------------------
// Line position PID steering - scan queue
// Two-entry queue between the front end and the PID back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lpps_pkg::scan_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lpps_pkg::scan_t pop_data
);

    lpps_pkg::scan_t                  entry_reg [lpps_pkg::QUEUE_DEPTH];
    logic [lpps_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [lpps_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [lpps_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [lpps_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [lpps_pkg::QCNT_W-1:0]      count_reg;
    logic [lpps_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = count_reg != lpps_pkg::QCNT_W'(lpps_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lpps_back.sv @@
// ----------------------------------------------------------------------------
// Line position PID steering - back end
// Restoring divider for the line error, PID law on one shared multiplier,
// duty saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lpps_pkg::cfg_t  cfg,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  lpps_pkg::scan_t pop_data,
    lpps_steer_if.source    steer
);

    lpps_pkg::back_state_t                 state_reg, state_next;
    logic [lpps_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic [lpps_pkg::DEN_W-1:0]            rem_reg, rem_next;
    logic [lpps_pkg::QUO_W-1:0]            nlow_reg, nlow_next;
    logic [lpps_pkg::DEN_W-1:0]            den_reg, den_next;
    logic [lpps_pkg::QUO_W-1:0]            quo_reg, quo_next;
    logic                                  neg_reg, neg_next;
    logic                                  black_reg, black_next;
    logic signed [lpps_pkg::ERR_W-1:0]     e_reg, e_next;
    logic signed [lpps_pkg::ERR_W-1:0]     last_reg, last_next;
    logic signed [lpps_pkg::INTEG_W-1:0]   integ_reg, integ_next;
    logic signed [lpps_pkg::DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [lpps_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic signed [lpps_pkg::CORR_W-1:0]    corr_reg, corr_next;
    logic signed [lpps_pkg::DUTY_Q_W-1:0]  left_v_reg, left_v_next;
    logic signed [lpps_pkg::DUTY_Q_W-1:0]  right_v_reg, right_v_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [lpps_pkg::DUTY_W-1:0]           left_out_reg, left_out_next;
    logic [lpps_pkg::DUTY_W-1:0]           right_out_reg, right_out_next;
    logic signed [lpps_pkg::ERR_W-1:0]     err_out_reg, err_out_next;

    logic [lpps_pkg::DEN_W:0]              trial;
    logic                                  trial_ge;
    logic [lpps_pkg::DEN_W:0]              trial_sub;
    logic signed [lpps_pkg::ERR_W-1:0]     quo_signed;
    logic signed [lpps_pkg::ERR_W-1:0]     e_val;
    logic signed [lpps_pkg::INTEG_W:0]     integ_sum;
    logic signed [lpps_pkg::INTEG_W:0]     lim_pos;
    logic signed [lpps_pkg::INTEG_W:0]     lim_neg;
    logic [lpps_pkg::GAIN_W-1:0]           mul_a;
    logic signed [lpps_pkg::INTEG_W-1:0]   mul_b;
    logic signed [lpps_pkg::PROD_W-1:0]    mul_prod;
    logic signed [lpps_pkg::CORR_W-1:0]    prod_ext;
    logic signed [lpps_pkg::DUTY_Q_W-1:0]  corr_ext;
    logic signed [lpps_pkg::DUTY_Q_W-1:0]  base_q;
    logic signed [lpps_pkg::DUTY_Q_W-1:0]  lo_q;
    logic signed [lpps_pkg::DUTY_Q_W-1:0]  hi_q;
    logic                                  out_free;

    function automatic logic [lpps_pkg::DUTY_W-1:0] sat_round(
        input logic signed [lpps_pkg::DUTY_Q_W-1:0] v,
        input logic signed [lpps_pkg::DUTY_Q_W-1:0] lo,
        input logic signed [lpps_pkg::DUTY_Q_W-1:0] hi
    );
        logic signed [lpps_pkg::DUTY_Q_W-1:0] s;
        logic [31:0]                          r;
        if (v > hi)
        begin
            s = hi;
        end
        else if (v < lo)
        begin
            s = lo;
        end
        else
        begin
            s = v;
        end
        r = s[31:0] + 32'h0000_8000;
        return r[30:16];
    endfunction

    assign pop_ready        = state_reg == lpps_pkg::ST_IDLE;
    assign steer.valid      = out_valid_reg;
    assign steer.left_duty  = left_out_reg;
    assign steer.right_duty = right_out_reg;
    assign steer.line_error = err_out_reg;
    assign out_free         = !out_valid_reg || steer.ready;

    assign trial     = {rem_reg, nlow_reg[lpps_pkg::QUO_W-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    assign quo_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign e_val      = black_reg
                        ? ((last_reg > 0) ? lpps_pkg::ERR_FULL : -lpps_pkg::ERR_FULL)
                        : quo_signed;
    assign integ_sum  = {integ_reg[lpps_pkg::INTEG_W-1], integ_reg}
                        + {{4{e_val[lpps_pkg::ERR_W-1]}}, e_val};
    assign lim_pos    = $signed({2'b0, cfg.integral_limit});
    assign lim_neg    = -lim_pos;

    assign mul_prod = $signed({1'b0, mul_a}) * mul_b;
    assign prod_ext = {{2{prod_reg[lpps_pkg::PROD_W-1]}}, prod_reg};
    assign corr_ext = {corr_reg[lpps_pkg::CORR_W-1], corr_reg};
    assign base_q   = $signed({14'b0, cfg.base_duty, 24'b0});
    assign lo_q     = $signed({14'b0, cfg.min_duty, 24'b0});
    assign hi_q     = $signed({14'b0, cfg.max_duty, 24'b0});

    always_comb
    begin
        case (state_reg)
            lpps_pkg::ST_MUL_I:
            begin
                mul_a = cfg.gain_i;
                mul_b = integ_reg;
            end
            lpps_pkg::ST_MUL_D:
            begin
                mul_a = cfg.gain_d;
                mul_b = {{2{diff_reg[lpps_pkg::DIFF_W-1]}}, diff_reg};
            end
            default:
            begin
                mul_a = cfg.gain_p;
                mul_b = {{3{e_reg[lpps_pkg::ERR_W-1]}}, e_reg};
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        nlow_next      = nlow_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        black_next     = black_reg;
        e_next         = e_reg;
        last_next      = last_reg;
        integ_next     = integ_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        corr_next      = corr_reg;
        left_v_next    = left_v_reg;
        right_v_next   = right_v_reg;
        out_valid_next = out_valid_reg && !steer.ready;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        err_out_next   = err_out_reg;

        case (state_reg)
            lpps_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    rem_next   = {2'b0, pop_data.num[lpps_pkg::NUM_W-1:lpps_pkg::QUO_W]};
                    nlow_next  = pop_data.num[lpps_pkg::QUO_W-1:0];
                    den_next   = pop_data.den;
                    neg_next   = pop_data.neg;
                    black_next = pop_data.all_black;
                    quo_next   = '0;
                    cnt_next   = lpps_pkg::DIV_STEPS;
                    state_next = pop_data.all_black ? lpps_pkg::ST_ERR : lpps_pkg::ST_DIV;
                end
            end
            lpps_pkg::ST_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[lpps_pkg::DEN_W-1:0]
                                     : trial[lpps_pkg::DEN_W-1:0];
                quo_next  = {quo_reg[lpps_pkg::QUO_W-2:0], trial_ge};
                nlow_next = {nlow_reg[lpps_pkg::QUO_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == 4'd1)
                begin
                    state_next = lpps_pkg::ST_ERR;
                end
            end
            lpps_pkg::ST_ERR:
            begin
                e_next    = e_val;
                last_next = e_val;
                diff_next = {e_val[lpps_pkg::ERR_W-1], e_val}
                            - {last_reg[lpps_pkg::ERR_W-1], last_reg};
                if (integ_sum > lim_pos)
                begin
                    integ_next = lim_pos[lpps_pkg::INTEG_W-1:0];
                end
                else if (integ_sum < lim_neg)
                begin
                    integ_next = lim_neg[lpps_pkg::INTEG_W-1:0];
                end
                else
                begin
                    integ_next = integ_sum[lpps_pkg::INTEG_W-1:0];
                end
                state_next = lpps_pkg::ST_MUL_P;
            end
            lpps_pkg::ST_MUL_P:
            begin
                prod_next  = mul_prod;
                state_next = lpps_pkg::ST_MUL_I;
            end
            lpps_pkg::ST_MUL_I:
            begin
                corr_next  = prod_ext;
                prod_next  = mul_prod;
                state_next = lpps_pkg::ST_MUL_D;
            end
            lpps_pkg::ST_MUL_D:
            begin
                corr_next  = corr_reg + prod_ext;
                prod_next  = mul_prod;
                state_next = lpps_pkg::ST_SUM;
            end
            lpps_pkg::ST_SUM:
            begin
                corr_next  = corr_reg + prod_ext;
                state_next = lpps_pkg::ST_DUTY;
            end
            lpps_pkg::ST_DUTY:
            begin
                left_v_next  = base_q - corr_ext;
                right_v_next = base_q + corr_ext;
                state_next   = lpps_pkg::ST_SAT;
            end
            lpps_pkg::ST_SAT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    left_out_next  = sat_round(left_v_reg, lo_q, hi_q);
                    right_out_next = sat_round(right_v_reg, lo_q, hi_q);
                    err_out_next   = e_reg;
                    state_next     = lpps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpps_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            integ_reg     <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        nlow_reg      <= nlow_next;
        den_reg       <= den_next;
        quo_reg       <= quo_next;
        neg_reg       <= neg_next;
        black_reg     <= black_next;
        e_reg         <= e_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        corr_reg      <= corr_next;
        left_v_reg    <= left_v_next;
        right_v_reg   <= right_v_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        err_out_reg   <= err_out_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/line_position_pid_steering.sv @@
// The back end takes a new scan only from idle; its work is set by the 13-step
// restoring divider, which an all-black scan skips, and the three passes of
// the shared 25x17 multiplier; a stalled steering channel also holds it.
// The two-entry queue takes up to two further scans while the back end works.
// Reset: rst_n restores config defaults and zeroes error history and integral.
// ----------------------------------------------------------------------------
// Line position PID steering - top level
// Configuration registers, front end, scan queue and PID back end.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_pid_steering (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lpps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpps_pkg::CFG_DATA_W-1:0] cfg_data,
    lpps_scan_if.sink                       scan,
    lpps_steer_if.source                    steer
);

    lpps_pkg::cfg_t  cfg_reg;
    lpps_pkg::cfg_t  cfg_next;
    lpps_pkg::scan_t push_data;
    lpps_pkg::scan_t pop_data;
    logic            push_valid;
    logic            push_ready;
    logic            pop_valid;
    logic            pop_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (lpps_pkg::cfg_index_t'(cfg_index))
                lpps_pkg::CFG_GAIN_P:          cfg_next.gain_p = cfg_data;
                lpps_pkg::CFG_GAIN_I:          cfg_next.gain_i = cfg_data;
                lpps_pkg::CFG_GAIN_D:          cfg_next.gain_d = cfg_data;
                lpps_pkg::CFG_BLACK_THRESHOLD:
                    cfg_next.black_threshold = cfg_data[lpps_pkg::SENSOR_W-1:0];
                lpps_pkg::CFG_BASE_DUTY:
                    cfg_next.base_duty = cfg_data[lpps_pkg::DUTY_CFG_W-1:0];
                lpps_pkg::CFG_MIN_DUTY:
                    cfg_next.min_duty = cfg_data[lpps_pkg::DUTY_CFG_W-1:0];
                lpps_pkg::CFG_MAX_DUTY:
                    cfg_next.max_duty = cfg_data[lpps_pkg::DUTY_CFG_W-1:0];
                lpps_pkg::CFG_INTEGRAL_LIMIT:
                    cfg_next.integral_limit = cfg_data[lpps_pkg::LIMIT_W-1:0];
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p          <= lpps_pkg::RST_GAIN_P;
            cfg_reg.gain_i          <= lpps_pkg::RST_GAIN_I;
            cfg_reg.gain_d          <= lpps_pkg::RST_GAIN_D;
            cfg_reg.black_threshold <= lpps_pkg::RST_THRESHOLD;
            cfg_reg.base_duty       <= lpps_pkg::RST_BASE_DUTY;
            cfg_reg.min_duty        <= lpps_pkg::RST_MIN_DUTY;
            cfg_reg.max_duty        <= lpps_pkg::RST_MAX_DUTY;
            cfg_reg.integral_limit  <= lpps_pkg::RST_INT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lpps_front u_front (
        .scan            (scan),
        .black_threshold (cfg_reg.black_threshold),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    lpps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lpps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .steer     (steer)
    );

endmodule

`default_nettype wire

@@ rtl/core/lpps_checker.sv @@
// ----------------------------------------------------------------------------
// Line position PID steering - port checker
// Watches the steering channel for range and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_position_pid_steering_macros.svh"

module lpps_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              steer_valid,
    input logic                              steer_ready,
    input logic [lpps_pkg::DUTY_W-1:0]       left_duty,
    input logic [lpps_pkg::DUTY_W-1:0]       right_duty,
    input logic signed [lpps_pkg::ERR_W-1:0] line_error
);

    `LPPS_ASSERT_NOW(a_error_range, clk, rst_n, steer_valid, (line_error <= lpps_pkg::ERR_FULL) && (line_error >= -lpps_pkg::ERR_FULL), "line error out of range")
    `LPPS_ASSERT_NOW(a_duty_range, clk, rst_n, steer_valid, (left_duty <= lpps_pkg::DUTY_MAX) && (right_duty <= lpps_pkg::DUTY_MAX), "duty above limit")
    `LPPS_ASSERT_NEXT(a_stall_hold, clk, rst_n, steer_valid && !steer_ready, steer_valid && $stable(left_duty) && $stable(right_duty) && $stable(line_error), "stalled beat changed")

endmodule

bind line_position_pid_steering lpps_checker u_lpps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .steer_valid (steer.valid),
    .steer_ready (steer.ready),
    .left_duty   (steer.left_duty),
    .right_duty  (steer.right_duty),
    .line_error  (steer.line_error)
);

`default_nettype wire

@@ tb/tb_line_position_pid_steering.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line position PID steering - testbench
// Drives five-sensor scans with random handshake gaps through several
// register settings. A predictor of the centroid error, the clamped integral
// and the saturated duties gives the expected steering beats, which are
// compared field by field.
// ----------------------------------------------------------------------------

module tb_line_position_pid_steering;

    import lpps_pkg::*;

    localparam int  NUM_PHASES  = 9;
    localparam int  QUIET_LIMIT = 3000;
    localparam int  TAIL_CYCLES = 40;
    localparam longint POS_SCALE = 2560;

    typedef logic [4:0][SENSOR_W-1:0] sensor_scan_t;

    typedef struct packed {
        logic [DUTY_W-1:0]       left_duty;
        logic [DUTY_W-1:0]       right_duty;
        logic signed [ERR_W-1:0] line_error;
    } steer_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = CFG_GAIN_P;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lpps_scan_if  scan_bus();
    lpps_steer_if steer_bus();

    line_position_pid_steering uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_bus),
        .steer     (steer_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cfg_t                    steer_cfg;
    logic signed [ERR_W-1:0]   held_error;
    logic signed [INTEG_W-1:0] error_accum;

    sensor_scan_t pending_scans[$];
    steer_beat_t  awaited_steer[$];
    sensor_scan_t drive_scan;
    sensor_scan_t taken_scan;
    steer_beat_t  want_beat;

    int unsigned scans_issued = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    logic        scan_fire = 1'b0;

    function automatic logic [DUTY_W-1:0] duty_q8(input longint v, input longint lo,
                                                 input longint hi);
        longint b;
        b = v;
        if (b > hi)
            b = hi;
        else if (b < lo)
            b = lo;
        return DUTY_W'((b + 32768) >>> 16);
    endfunction

    function automatic steer_beat_t predict_steering(input sensor_scan_t rd);
        longint      weighted, total, mag, quot, err, slope, integ, lim, corr;
        longint      centre, lo, hi;
        bit          any_white;
        steer_beat_t beat;
        weighted = 3 * (longint'(rd[0]) - longint'(rd[4])) + longint'(rd[1])
                   - longint'(rd[3]);
        total = longint'(rd[0]) + longint'(rd[1]) + longint'(rd[2]) + longint'(rd[3])
                + longint'(rd[4]);
        any_white = 1'b0;
        for (int k = 0; k < 5; k++)
            if (rd[k] > steer_cfg.black_threshold)
                any_white = 1'b1;
        if (!any_white)
            err = (held_error > 0) ? longint'(ERR_FULL) : -longint'(ERR_FULL);
        else if (total == 0)
            err = 0;
        else
        begin
            mag  = (weighted < 0) ? -weighted : weighted;
            quot = (2 * mag * POS_SCALE + total) / (2 * total);
            err  = (weighted < 0) ? -quot : quot;
        end
        slope = err - longint'(held_error);
        lim   = longint'(steer_cfg.integral_limit);
        integ = longint'(error_accum) + err;
        if (integ > lim)
            integ = lim;
        else if (integ < -lim)
            integ = -lim;
        error_accum = INTEG_W'(integ);
        corr = longint'(steer_cfg.gain_p) * err + longint'(steer_cfg.gain_i) * integ
               + longint'(steer_cfg.gain_d) * slope;
        centre = longint'(steer_cfg.base_duty) << 24;
        lo     = longint'(steer_cfg.min_duty) << 24;
        hi     = longint'(steer_cfg.max_duty) << 24;
        beat.left_duty  = duty_q8(centre - corr, lo, hi);
        beat.right_duty = duty_q8(centre + corr, lo, hi);
        beat.line_error = ERR_W'(err);
        held_error = ERR_W'(err);
        return beat;
    endfunction

    function automatic sensor_scan_t scan_of(input int s0, input int s1, input int s2,
                                             input int s3, input int s4);
        sensor_scan_t s;
        s[0] = SENSOR_W'(s0);
        s[1] = SENSOR_W'(s1);
        s[2] = SENSOR_W'(s2);
        s[3] = SENSOR_W'(s3);
        s[4] = SENSOR_W'(s4);
        return s;
    endfunction

    function automatic logic [SENSOR_W-1:0] reading_near(input bit dark, input int unsigned thr);
        if (dark)
            return SENSOR_W'($urandom_range(thr, 0));
        if (thr >= 1023)
            return SENSOR_W'(1023);
        return SENSOR_W'($urandom_range(1023, thr + 1));
    endfunction

    function automatic sensor_scan_t random_scan();
        sensor_scan_t s;
        int unsigned  thr, shape, pos, span;
        thr   = steer_cfg.black_threshold;
        shape = $urandom_range(99);
        pos   = $urandom_range(4);
        span  = $urandom_range(2, 1);
        for (int k = 0; k < 5; k++)
            s[k] = SENSOR_W'($urandom);
        if (shape < 55)
        begin
            for (int k = 0; k < 5; k++)
                s[k] = reading_near(k >= pos && k < pos + span, thr);
        end
        else if (shape < 75)
        begin
            for (int k = 0; k < 5; k++)
                s[k] = reading_near(1'b1, thr);
        end
        else if (shape < 80)
            s = shape[0] ? '0 : '1;
        return s;
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(2))
            0:       return GAIN_W'($urandom_range(32'h3FFFF));
            1:       return GAIN_W'($urandom_range(32'h3FFFFF));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic cfg_t phase_settings(input int phase);
        cfg_t c;
        c.gain_p          = random_gain();
        c.gain_i          = random_gain();
        c.gain_d          = random_gain();
        c.black_threshold = SENSOR_W'($urandom_range(900, 100));
        c.base_duty       = DUTY_CFG_W'($urandom_range(100, 30));
        c.min_duty        = DUTY_CFG_W'($urandom_range(60, 0));
        c.max_duty        = DUTY_CFG_W'($urandom_range(127, 50));
        c.integral_limit  = LIMIT_W'($urandom);
        case (phase)
            1:
            begin
                c.gain_p          = '1;
                c.gain_i          = '1;
                c.gain_d          = '1;
                c.black_threshold = '0;
                c.base_duty       = 7'd100;
                c.min_duty        = '0;
                c.max_duty        = 7'd100;
                c.integral_limit  = '1;
            end
            2:
            begin
                c.gain_p          = '0;
                c.gain_i          = '0;
                c.gain_d          = '0;
                c.black_threshold = 10'd1000;
                c.base_duty       = '1;
                c.min_duty        = '0;
                c.max_duty        = '1;
                c.integral_limit  = '0;
            end
            3:
            begin
                c.gain_p    = 24'h020000;
                c.gain_i    = 24'h000400;
                c.gain_d    = 24'h008000;
                c.base_duty = 7'd50;
                c.min_duty  = 7'd100;
                c.max_duty  = 7'd20;
            end
            4:
            begin
                c.black_threshold = '1;
                c.integral_limit  = 16'd1;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                       input int w);
        return v | (CFG_DATA_W'($urandom) << w);
    endfunction

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_GAIN_P:          steer_cfg.gain_p          = data[GAIN_W-1:0];
            CFG_GAIN_I:          steer_cfg.gain_i          = data[GAIN_W-1:0];
            CFG_GAIN_D:          steer_cfg.gain_d          = data[GAIN_W-1:0];
            CFG_BLACK_THRESHOLD: steer_cfg.black_threshold = data[SENSOR_W-1:0];
            CFG_BASE_DUTY:       steer_cfg.base_duty       = data[DUTY_CFG_W-1:0];
            CFG_MIN_DUTY:        steer_cfg.min_duty        = data[DUTY_CFG_W-1:0];
            CFG_MAX_DUTY:        steer_cfg.max_duty        = data[DUTY_CFG_W-1:0];
            CFG_INTEGRAL_LIMIT:  steer_cfg.integral_limit  = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_register(CFG_GAIN_P, c.gain_p);
        write_register(CFG_GAIN_I, c.gain_i);
        write_register(CFG_GAIN_D, c.gain_d);
        write_register(CFG_BLACK_THRESHOLD, with_junk(c.black_threshold, SENSOR_W));
        write_register(CFG_BASE_DUTY, with_junk(c.base_duty, DUTY_CFG_W));
        write_register(CFG_MIN_DUTY, with_junk(c.min_duty, DUTY_CFG_W));
        write_register(CFG_MAX_DUTY, with_junk(c.max_duty, DUTY_CFG_W));
        write_register(CFG_INTEGRAL_LIMIT, with_junk(c.integral_limit, LIMIT_W));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_scan(input sensor_scan_t s);
        pending_scans.push_back(s);
        scans_issued++;
    endtask

    task automatic wait_drained();
        while (results_checked != scans_issued || pending_scans.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // hold the beat until taken, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            scan_bus.valid <= 1'b0;
        else if (!scan_bus.valid || scan_fire)
        begin
            if (pending_scans.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                drive_scan = pending_scans.pop_front();
                scan_bus.valid    <= 1'b1;
                scan_bus.sensor_0 <= drive_scan[0];
                scan_bus.sensor_1 <= drive_scan[1];
                scan_bus.sensor_2 <= drive_scan[2];
                scan_bus.sensor_3 <= drive_scan[3];
                scan_bus.sensor_4 <= drive_scan[4];
            end
            else
                scan_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            steer_bus.ready <= 1'b0;
        else
            steer_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        scan_fire    <= rst_n && scan_bus.valid && scan_bus.ready;
        quiet_cycles <= ((scan_bus.valid && scan_bus.ready)
                         || (steer_bus.valid && steer_bus.ready)) ? 0 : quiet_cycles + 1;
        if (rst_n && scan_bus.valid && scan_bus.ready)
        begin
            taken_scan = {scan_bus.sensor_4, scan_bus.sensor_3, scan_bus.sensor_2,
                          scan_bus.sensor_1, scan_bus.sensor_0};
            awaited_steer.push_back(predict_steering(taken_scan));
        end
        if (rst_n && steer_bus.valid && steer_bus.ready)
        begin
            if (awaited_steer.size() == 0)
            begin
                $display("%0t: steering beat with none expected, actual %0d %0d %0d", $time,
                         steer_bus.left_duty, steer_bus.right_duty, steer_bus.line_error);
                mismatches++;
            end
            else
            begin
                want_beat = awaited_steer.pop_front();
                check_field("left_duty", want_beat.left_duty, steer_bus.left_duty);
                check_field("right_duty", want_beat.right_duty, steer_bus.right_duty);
                check_field("line_error", want_beat.line_error, steer_bus.line_error);
                results_checked++;
            end
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        scan_bus.valid    = 1'b0;
        scan_bus.sensor_0 = '0;
        scan_bus.sensor_1 = '0;
        scan_bus.sensor_2 = '0;
        scan_bus.sensor_3 = '0;
        scan_bus.sensor_4 = '0;
        steer_bus.ready   = 1'b0;
        steer_cfg   = '{RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_THRESHOLD, RST_BASE_DUTY,
                        RST_MIN_DUTY, RST_MAX_DUTY, RST_INT_LIMIT};
        held_error  = '0;
        error_accum = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            if (phase > 0)
                apply_settings(phase_settings(phase));
            if (phase < 3)
            begin
                sender_idle_pct   = 28;
                receiver_idle_pct = 81;
            end
            else if (phase < 6)
            begin
                sender_idle_pct   = 81;
                receiver_idle_pct = 28;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (phase == 0)
            begin
                queue_scan(scan_of(0, 0, 0, 0, 0));
                queue_scan(scan_of(1023, 0, 0, 0, 0));
                queue_scan(scan_of(0, 0, 0, 0, 0));
                queue_scan(scan_of(400, 300, 200, 100, 0));
                queue_scan(scan_of(0, 0, 0, 0, 1023));
                queue_scan(scan_of(500, 500, 500, 500, 500));
                queue_scan(scan_of(501, 500, 500, 500, 500));
                queue_scan(scan_of(1023, 1023, 1023, 1023, 1023));
                queue_scan(scan_of(0, 1, 1023, 0, 0));
                queue_scan(scan_of(0, 0, 1023, 1, 0));
                queue_scan(scan_of(1000, 1000, 0, 0, 0));
                queue_scan(scan_of(0, 0, 0, 1000, 1000));
                queue_scan(scan_of(0, 1023, 0, 0, 0));
                queue_scan(scan_of(1023, 1023, 0, 1023, 1023));
                queue_scan(scan_of(0, 0, 1023, 0, 0));
            end
            repeat ((phase == 0) ? 100 : (phase == 2 || phase == 4) ? 50 : 135)
                queue_scan(random_scan());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && awaited_steer.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
